>>> rtl/vn_pkg.sv
package vn_pkg;

  localparam int IN_WIDTH      = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int OUT_WIDTH     = OUT_FRAC_BITS + 2;

  // magnitude, squared length, partial product r*s, remainder widths
  localparam int MW  = IN_WIDTH;
  localparam int SW  = 2 * IN_WIDTH;
  localparam int RBW = OUT_FRAC_BITS + 1;
  localparam int QW  = SW + RBW;
  localparam int RW  = 2 * IN_WIDTH + 2 * OUT_FRAC_BITS + 6;
  localparam int NCELL = OUT_FRAC_BITS + 1;

  typedef struct packed {
    logic signed [IN_WIDTH-1:0] vec_x;
    logic signed [IN_WIDTH-1:0] vec_y;
    logic signed [IN_WIDTH-1:0] vec_z;
  } vec_in_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] unit_x;
    logic signed [OUT_WIDTH-1:0] unit_y;
    logic signed [OUT_WIDTH-1:0] unit_z;
    logic                        was_zero;
  } vec_out_t;

  // one component in flight: remainder, r*s, result bits so far, sign
  typedef struct packed {
    logic [RW-1:0]  rem;
    logic [QW-1:0]  q;
    logic [RBW-1:0] r;
    logic           neg;
  } lane_t;

  typedef struct packed {
    logic            valid;
    logic            zero;
    logic [SW-1:0]   s;
    lane_t [2:0]     lane;
  } cell_t;

endpackage

>>> rtl/vector3_normalize.sv
// vector3_normalize: scales a signed 3-vector to unit length, Q1.14 output.
// Input channel: drive vec and raise start; a beat is taken at each rising
// edge with start high. busy is always low, so one vector per cycle.
// Output channel: done pulses for one cycle with result valid in that
// cycle; the receiver must take it then, there is no back-pressure.
// Pipeline: abs, square and sum stages, one cell per result bit, then the
// registered output stage that raises done.
// Throughput: one vector per clock, sustained.
// A zero vector gives unit_x = 1.0, unit_y = unit_z = 0 and was_zero set.
// Reset (rst, synchronous) drops every beat in flight; no data is cleared.
module vector3_normalize (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  vn_pkg::vec_in_t   vec,
  output logic              done,
  output vn_pkg::vec_out_t  result
);

  localparam int F = vn_pkg::OUT_FRAC_BITS;

  logic                   v0, v1;
  logic [vn_pkg::MW-1:0]  mag0 [3];
  logic [2:0]             neg0, neg1;
  logic [vn_pkg::SW-1:0]  sq1 [3];
  logic signed [vn_pkg::IN_WIDTH-1:0] comp [3];
  vn_pkg::cell_t chain [vn_pkg::NCELL+1];
  vn_pkg::cell_t init_next;
  logic [vn_pkg::SW+1:0]  ssum;

  assign busy = 1'b0;
  assign comp[0] = vec.vec_x;
  assign comp[1] = vec.vec_y;
  assign comp[2] = vec.vec_z;

  // stage 0: magnitudes and signs
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      v0 <= start;
      v1 <= v0;
    end
    for (int i = 0; i < 3; i++) begin
      neg0[i] <= comp[i][vn_pkg::IN_WIDTH-1];
      mag0[i] <= comp[i][vn_pkg::IN_WIDTH-1] ? vn_pkg::MW'(-comp[i])
                                              : vn_pkg::MW'(comp[i]);
    end
  end

  // stage 1: squares
  always_ff @(posedge clk) begin
    neg1 <= neg0;
    for (int i = 0; i < 3; i++) begin
      sq1[i] <= vn_pkg::SW'(mag0[i]) * vn_pkg::SW'(mag0[i]);
    end
  end

  // stage 2: squared length, remainder starts at 4 * mag^2 * 2^(2F)
  always_comb begin
    ssum = (vn_pkg::SW+2)'(sq1[0]) + (vn_pkg::SW+2)'(sq1[1]) + (vn_pkg::SW+2)'(sq1[2]);
    init_next.valid = v1;
    init_next.s     = vn_pkg::SW'(ssum);
    init_next.zero  = (ssum == '0);
    for (int i = 0; i < 3; i++) begin
      init_next.lane[i].rem = vn_pkg::RW'(sq1[i]) << (2 * F + 2);
      init_next.lane[i].q   = '0;
      init_next.lane[i].r   = '0;
      init_next.lane[i].neg = neg1[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else begin
      chain[0].valid <= init_next.valid;
    end
    chain[0].zero <= init_next.zero;
    chain[0].s    <= init_next.s;
    chain[0].lane <= init_next.lane;
  end

  // bit cells, MSB first
  for (genvar g = 0; g < vn_pkg::NCELL; g++) begin : g_cell
    vn_cell #(.BIT(F - g)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  // output stage: sign and zero-length default
  vn_pkg::vec_out_t res_next;
  logic [vn_pkg::OUT_WIDTH-1:0] u [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u[i] = vn_pkg::OUT_WIDTH'(chain[vn_pkg::NCELL].lane[i].r);
      if (chain[vn_pkg::NCELL].lane[i].neg) begin
        u[i] = -u[i];
      end
    end
    res_next.unit_x   = u[0];
    res_next.unit_y   = u[1];
    res_next.unit_z   = u[2];
    res_next.was_zero = chain[vn_pkg::NCELL].zero;
    if (chain[vn_pkg::NCELL].zero) begin
      res_next.unit_x = vn_pkg::OUT_WIDTH'(1) << F;
      res_next.unit_y = '0;
      res_next.unit_z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain[vn_pkg::NCELL].valid;
    end
    result <= res_next;
  end

endmodule

>>> rtl/vn_cell.sv
// One result bit per cell: tries setting bit BIT of r for all three lanes.
// Test: (2c-1)^2 * s <= 4 * mag^2 * 2^(2F), kept incrementally in rem.
module vn_cell #(
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  vn_pkg::cell_t  din,
  output vn_pkg::cell_t  dout
);

  vn_pkg::cell_t nxt;
  logic [vn_pkg::RW-1:0] s_ext;
  logic [vn_pkg::RW-1:0] dlt [3];
  logic [vn_pkg::RW-1:0] q_ext [3];

  always_comb begin
    nxt   = din;
    s_ext = vn_pkg::RW'(din.s);
    for (int i = 0; i < 3; i++) begin
      q_ext[i] = vn_pkg::RW'(din.lane[i].q);
      // growth of 4c^2 s - 4c s when c gains 2^BIT
      dlt[i] = (q_ext[i] << (BIT + 3)) + (s_ext << (2 * BIT + 2)) - (s_ext << (BIT + 2));
      if (dlt[i] + s_ext <= din.lane[i].rem) begin
        nxt.lane[i].rem = din.lane[i].rem - dlt[i];
        nxt.lane[i].q   = din.lane[i].q + vn_pkg::QW'(s_ext << BIT);
        nxt.lane[i].r   = din.lane[i].r | (vn_pkg::RBW'(1) << BIT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= nxt.valid;
    end
    dout.zero <= nxt.zero;
    dout.s    <= nxt.s;
    dout.lane <= nxt.lane;
  end

endmodule
